// ===== hw/rtl/srsw_pkg.sv =====
// Package for the selective-repeat sender window unit.
// Holds field widths, event and register codes, and the result transfer struct.
// No dependencies.
`default_nettype none

package srsw_pkg;

  localparam int unsigned ID_W            = 11;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned WIN_CFG_W       = 6;
  localparam int unsigned TOTAL_CFG_W     = 11;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 11;
  localparam int unsigned MAX_PACKETS_DEF = 1024;
  localparam int unsigned MAX_WINDOW_DEF  = 32;

  localparam logic [WIN_CFG_W-1:0] WINDOW_RST = 6'd10;

  // Event codes.
  localparam logic [FUNC_W-1:0] FN_START = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ACK   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TOUT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd1;

  // Bit positions in a map entry.
  localparam int unsigned ACK_BIT    = 0;
  localparam int unsigned RESENT_BIT = 1;

  // One step from the sequencer to the result stage.
  typedef struct packed {
    logic            push;       // a send id is produced
    logic            fin;        // the event is complete
    logic [ID_W-1:0] id;
    logic            resend;
    logic            all_acked;
  } emit_t;

endpackage : srsw_pkg

`default_nettype wire

// ===== hw/rtl/srsw_map_mem.sv =====
// Per-packet map memory: acknowledged and retransmitted bits, one write and
// one registered read port. Does not depend on srsw_pkg.
`default_nettype none

module srsw_map_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [1:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [1:0]    rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : srsw_map_mem

`default_nettype wire

// ===== hw/rtl/srsw_seq.sv =====
// Sequencer of the sender window: event decoding, map clearing, base slide,
// new sends and timeout resends, one map entry per cycle. Uses srsw_pkg.
`default_nettype none

module srsw_seq #(
  parameter int unsigned MAX_PACKETS = 1024,
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned AW          = 10
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic [srsw_pkg::FUNC_W-1:0]          func_i,
  input  wire logic [srsw_pkg::ID_W-1:0]            ack_id_i,
  input  wire logic [srsw_pkg::WIN_CFG_W-1:0]       window_i,
  input  wire logic [srsw_pkg::TOTAL_CFG_W-1:0]     total_i,
  output logic                                      busy_o,
  output logic                                      we_o,
  output logic      [AW-1:0]                        waddr_o,
  output logic      [1:0]                           wdata_o,
  output logic      [AW-1:0]                        raddr_o,
  input  wire logic [1:0]                           rdata_i,
  output srsw_pkg::emit_t                           ev_o
);

  import srsw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PACKETS + 2);
  localparam int unsigned LW = CW + 1;
  localparam int unsigned NW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_ACK_RD,
    S_ACK_CHK,
    S_SLIDE,
    S_SEND,
    S_TOUT,
    S_FLUSH
  } state_e;

  state_e          state_q, state_d;
  logic            started_q, started_d;
  logic [CW-1:0]   base_q, base_d;
  logic [CW-1:0]   next_q, next_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [NW-1:0]   n_q, n_d;
  logic [NW-1:0]   s_q, s_d;
  logic            rv_q, rv_d;
  logic [AW-1:0]   ack_addr_q, ack_addr_d;

  logic [NW-1:0]   w_eff;
  logic [CW-1:0]   t_eff;
  logic [LW-1:0]   base_w;
  logic [CW-1:0]   lim;
  logic [31:0]     id_ext;

  // Effective window (zero taken as one) and total, saturated from the live registers.
  always_comb begin
    if (window_i == '0) begin
      w_eff = NW'(1);
    end else if (32'(window_i) > 32'(MAX_WINDOW)) begin
      w_eff = NW'(MAX_WINDOW);
    end else begin
      w_eff = NW'(window_i);
    end
    if (32'(total_i) > 32'(MAX_PACKETS)) begin
      t_eff = CW'(MAX_PACKETS);
    end else begin
      t_eff = CW'(total_i);
    end
    base_w = LW'(base_q) + LW'(w_eff);
    lim    = (base_w > LW'(t_eff)) ? t_eff : CW'(base_w);
    id_ext = 32'(ack_id_i);
  end

  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    base_d     = base_q;
    next_d     = next_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    n_d        = n_q;
    s_d        = s_q;
    rv_d       = rv_q;
    ack_addr_d = ack_addr_q;
    we_o       = 1'b0;
    waddr_o    = '0;
    wdata_o    = '0;
    raddr_o    = '0;
    ev_o       = '0;
    ev_o.all_acked = (cnt_q == '0);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d  = '0;
          rv_d = 1'b0;
          case (func_i)
            FN_START: begin
              started_d = 1'b1;
              base_d    = '0;
              next_d    = CW'(1);
              cnt_d     = t_eff;
              ptr_d     = '0;
              state_d   = S_CLEAR;
            end
            FN_ACK: begin
              if (!started_q) begin
                state_d = S_FLUSH;
              end else if (id_ext >= 32'd1 && id_ext <= 32'(t_eff)) begin
                ack_addr_d = AW'(id_ext - 32'd1);
                state_d    = S_ACK_RD;
              end else begin
                s_d     = '0;
                state_d = S_SLIDE;
              end
            end
            FN_TOUT: begin
              if (started_q) begin
                ptr_d   = base_q;
                state_d = S_TOUT;
              end else begin
                state_d = S_FLUSH;
              end
            end
            default: begin
              state_d = S_FLUSH;
            end
          endcase
        end
      end

      S_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = AW'(ptr_q);
        wdata_o = '0;
        if (ptr_q == CW'(MAX_PACKETS - 1)) begin
          rv_d    = 1'b0;
          state_d = S_SEND;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end

      S_ACK_RD: begin
        raddr_o = ack_addr_q;
        state_d = S_ACK_CHK;
      end

      S_ACK_CHK: begin
        if (!rdata_i[ACK_BIT]) begin
          we_o    = 1'b1;
          waddr_o = ack_addr_q;
          wdata_o = {rdata_i[RESENT_BIT], 1'b1};
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CW'(1);
          end
        end
        s_d     = '0;
        rv_d    = 1'b0;
        state_d = S_SLIDE;
      end

      // The read of the following entry is issued while the current one is
      // checked; a wasted read past the end of the slide is harmless.
      S_SLIDE: begin
        raddr_o = rv_q ? AW'(base_q + CW'(1)) : AW'(base_q);
        rv_d    = 1'b1;
        if (s_q >= w_eff || base_q >= t_eff || (rv_q && !rdata_i[ACK_BIT])) begin
          next_d  = (next_q < base_q + CW'(1)) ? base_q + CW'(1) : next_q;
          rv_d    = 1'b0;
          state_d = S_SEND;
        end else if (rv_q) begin
          base_d = base_q + CW'(1);
          s_d    = s_q + NW'(1);
        end
      end

      S_SEND: begin
        if (next_q > lim || n_q >= NW'(MAX_WINDOW)) begin
          rv_d    = 1'b0;
          state_d = S_FLUSH;
        end else begin
          raddr_o = rv_q ? AW'(next_q) : AW'(next_q - CW'(1));
          rv_d    = 1'b1;
          if (rv_q) begin
            if (!rdata_i[ACK_BIT]) begin
              ev_o.push   = 1'b1;
              ev_o.id     = ID_W'(next_q);
              ev_o.resend = 1'b0;
              n_d         = n_q + NW'(1);
            end
            next_d = next_q + CW'(1);
          end
        end
      end

      S_TOUT: begin
        if (ptr_q >= lim || n_q >= NW'(MAX_WINDOW)) begin
          rv_d    = 1'b0;
          state_d = S_FLUSH;
        end else begin
          raddr_o = rv_q ? AW'(ptr_q + CW'(1)) : AW'(ptr_q);
          rv_d    = 1'b1;
          if (rv_q) begin
            if (!rdata_i[ACK_BIT] && !rdata_i[RESENT_BIT]) begin
              we_o        = 1'b1;
              waddr_o     = AW'(ptr_q);
              wdata_o     = 2'b10;
              ev_o.push   = 1'b1;
              ev_o.id     = ID_W'(ptr_q + CW'(1));
              ev_o.resend = 1'b1;
              n_d         = n_q + NW'(1);
            end
            ptr_d = ptr_q + CW'(1);
          end
        end
      end

      S_FLUSH: begin
        ev_o.fin = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      started_q  <= 1'b0;
      base_q     <= '0;
      next_q     <= CW'(1);
      cnt_q      <= '0;
      ptr_q      <= '0;
      n_q        <= '0;
      s_q        <= '0;
      rv_q       <= 1'b0;
      ack_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      started_q  <= started_d;
      base_q     <= base_d;
      next_q     <= next_d;
      cnt_q      <= cnt_d;
      ptr_q      <= ptr_d;
      n_q        <= n_d;
      s_q        <= s_d;
      rv_q       <= rv_d;
      ack_addr_q <= ack_addr_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule : srsw_seq

`default_nettype wire

// ===== hw/rtl/srsw_result.sv =====
// Result stage: holds one produced send id back so that the final result of
// an event can carry the last flag, then drives the result ports. Uses srsw_pkg.
`default_nettype none

module srsw_result (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire srsw_pkg::emit_t            ev_i,
  output logic                            result_valid_o,
  output logic [srsw_pkg::ID_W-1:0]       send_id_o,
  output logic                            is_resend_o,
  output logic                            all_acked_o,
  output logic                            last_o
);

  import srsw_pkg::*;

  logic            pend_v_q;
  logic [ID_W-1:0] pend_id_q;
  logic            pend_rs_q;
  logic            valid_q;
  logic [ID_W-1:0] id_q;
  logic            rs_q;
  logic            acked_q;
  logic            last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (ev_i.fin) begin
        valid_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else if (ev_i.push) begin
        valid_q  <= pend_v_q;
        pend_v_q <= 1'b1;
      end
    end
  end

  // With no id produced, the event still ends with one empty result.
  always_ff @(posedge clk_i) begin
    acked_q <= ev_i.all_acked;
    if (ev_i.fin) begin
      id_q   <= pend_v_q ? pend_id_q : '0;
      rs_q   <= pend_v_q & pend_rs_q;
      last_q <= 1'b1;
    end else if (ev_i.push) begin
      id_q      <= pend_id_q;
      rs_q      <= pend_rs_q;
      last_q    <= 1'b0;
      pend_id_q <= ev_i.id;
      pend_rs_q <= ev_i.resend;
    end
  end

  assign result_valid_o = valid_q;
  assign send_id_o      = id_q;
  assign is_resend_o    = rs_q;
  assign all_acked_o    = acked_q;
  assign last_o         = last_q;

endmodule : srsw_result

`default_nettype wire

// ===== hw/rtl/selective_repeat_sender_window_unit.sv =====
// Top level of the selective-repeat sender window unit.
// Holds the configuration registers and ties the sequencer, map memory and
// result stage together. Uses srsw_pkg, srsw_seq, srsw_map_mem, srsw_result.
//
// Usage: an event (func_i, ack_id_i) is taken when start_i is high and busy_o
// is low; codes are start, acknowledgement and timeout. Each event gives one or
// more results, each shown for one cycle with result_valid_o high; the last one
// has last_o set, and an event that sends nothing gives one result with id zero.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the window size, index 1 the packet count. Write only while idle.
// Timing: the maps are visited one entry per cycle, one event at a time. busy_o
// stays high while an acknowledgement checks its id, slides the base and scans
// for new ids, while a timeout scans the window for resends, and while a start
// clears all MAX_PACKETS map entries and then sends. Each send id is held until
// the next one or the end of the event is seen; the final result shows in the
// first cycle with busy_o low, and the next event can be taken at the edge that
// ends that cycle.
// Reset clears all control state; acknowledgements and timeouts before the
// first start produce only the empty result. The receiver cannot stall.
`default_nettype none

module selective_repeat_sender_window_unit #(
  parameter int unsigned MAX_PACKETS = srsw_pkg::MAX_PACKETS_DEF,
  parameter int unsigned MAX_WINDOW  = srsw_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [srsw_pkg::FUNC_W-1:0]       func_i,
  input  wire logic [srsw_pkg::ID_W-1:0]         ack_id_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                   result_valid_o,
  output logic [srsw_pkg::ID_W-1:0]              send_id_o,
  output logic                                   is_resend_o,
  output logic                                   all_acked_o,
  output logic                                   last_o
);

  import srsw_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PACKETS);

  logic [WIN_CFG_W-1:0]   window_q;
  logic [TOTAL_CFG_W-1:0] total_q;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [1:0]             wdata;
  logic [AW-1:0]          raddr;
  logic [1:0]             rdata;
  emit_t                  ev;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RST;
      total_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WINDOW: window_q <= cfg_data_i[WIN_CFG_W-1:0];
        CFG_TOTAL:  total_q  <= cfg_data_i[TOTAL_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srsw_seq #(
    .MAX_PACKETS (MAX_PACKETS),
    .MAX_WINDOW  (MAX_WINDOW),
    .AW          (AW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .func_i   (func_i),
    .ack_id_i (ack_id_i),
    .window_i (window_q),
    .total_i  (total_q),
    .busy_o   (busy_o),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .ev_o     (ev)
  );

  srsw_map_mem #(
    .DEPTH (MAX_PACKETS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  srsw_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ev_i           (ev),
    .result_valid_o (result_valid_o),
    .send_id_o      (send_id_o),
    .is_resend_o    (is_resend_o),
    .all_acked_o    (all_acked_o),
    .last_o         (last_o)
  );

endmodule : selective_repeat_sender_window_unit

`default_nettype wire

// ===== tb/sv/selective_repeat_sender_window_unit_tb.sv =====
// Self-checking testbench for selective_repeat_sender_window_unit.
// Drives start, acknowledgement and timeout events plus register writes, and checks every
// send result against a cycle-free window tracker. Depends on srsw_pkg and the RTL only.
module selective_repeat_sender_window_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srsw_pkg::*;

  localparam int unsigned MAX_PKT   = MAX_PACKETS_DEF;
  localparam int unsigned MAX_WIN   = MAX_WINDOW_DEF;
  localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;
  localparam int unsigned RAND_ITEMS = 410;
  localparam int unsigned CFG_PAUSE  = 8;
  localparam int unsigned END_PAUSE  = 2 * MAX_WIN + 16;
  // A start clears all MAX_PKT map entries; even a run made of starts only,
  // each behind the longest sender gap, stays well below this limit.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PRINT_CAP   = 50;

  typedef struct packed {
    logic [ID_W-1:0] send_id;
    logic            is_resend;
    logic            all_acked;
    logic            last;
  } planned_send_t;

  class sender_window_tracker;
    bit acked [MAX_PKT];
    bit resent [MAX_PKT];
    int unsigned base;
    int unsigned next_id;
    int unsigned unacked;
    bit started;
    logic [WIN_CFG_W-1:0] win_reg;
    logic [TOTAL_CFG_W-1:0] total_reg;
    planned_send_t planned_sends[$];
    planned_send_t batch[$];
    int unsigned mismatch_cnt;

    function new();
      win_reg = WINDOW_RST;
      total_reg = '0;
      started = 1'b0;
      base = 0;
      next_id = 1;
      unacked = 0;
      mismatch_cnt = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_WINDOW) begin
        win_reg = data[WIN_CFG_W-1:0];
      end else if (idx == CFG_TOTAL) begin
        total_reg = data[TOTAL_CFG_W-1:0];
      end
    endfunction

    function int unsigned eff_window();
      if (win_reg == 0) return 1;
      if (win_reg > MAX_WIN) return MAX_WIN;
      return win_reg;
    endfunction

    function int unsigned eff_total();
      if (total_reg > MAX_PKT) return MAX_PKT;
      return total_reg;
    endfunction

    function int unsigned pending();
      return planned_sends.size();
    endfunction

    function void emit_send(int unsigned id, bit rs);
      planned_send_t rec;
      rec.send_id = ID_W'(id);
      rec.is_resend = rs;
      rec.all_acked = 1'b0;
      rec.last = 1'b0;
      batch.insert(batch.size(), rec);
    endfunction

    // Sends the ids that have entered the window; ids acknowledged early are skipped.
    function void send_fresh();
      int unsigned lim;
      lim = base + eff_window();
      if (lim > eff_total()) lim = eff_total();
      if (next_id < base + 1) next_id = base + 1;
      while (next_id <= lim && batch.size() < MAX_WIN) begin
        if (!acked[next_id-1]) emit_send(next_id, 1'b0);
        next_id++;
      end
    endfunction

    function void take_event(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id);
      int unsigned t;
      int unsigned w;
      int unsigned stop;
      int unsigned i;
      int unsigned s;
      t = eff_total();
      w = eff_window();
      batch.delete();
      if (fn == FN_START) begin
        foreach (acked[j]) begin
          acked[j] = 1'b0;
          resent[j] = 1'b0;
        end
        base = 0;
        next_id = 1;
        unacked = t;
        started = 1'b1;
        send_fresh();
      end else if (fn == FN_ACK && started) begin
        if (id >= 1 && int'(id) <= t && !acked[id-1]) begin
          acked[id-1] = 1'b1;
          if (unacked > 0) unacked--;
        end
        for (s = 0; s < w && base < t && acked[base]; s++) base++;
        send_fresh();
      end else if (fn == FN_TOUT && started) begin
        stop = base + w;
        if (stop > t) stop = t;
        for (i = base; i < stop && batch.size() < MAX_WIN; i++) begin
          if (!acked[i] && !resent[i]) begin
            resent[i] = 1'b1;
            emit_send(i + 1, 1'b1);
          end
        end
      end
      if (batch.size() == 0) emit_send(0, 1'b0);
      foreach (batch[k]) begin
        batch[k].all_acked = (unacked == 0);
        batch[k].last = (k == batch.size() - 1);
        planned_sends.insert(planned_sends.size(), batch[k]);
      end
    endfunction

    // A random id that was sent and still waits for its acknowledgement, or zero.
    function int unsigned pick_outstanding();
      int unsigned cand[$];
      int unsigned i;
      int unsigned top;
      top = next_id - 1;
      if (top > eff_total()) top = eff_total();
      for (i = base + 1; i <= top; i++) begin
        if (!acked[i-1]) cand.insert(cand.size(), i);
      end
      if (cand.size() == 0) return 0;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task report(string msg);
      if (mismatch_cnt < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_cnt++;
    endtask

    task match_send(logic [ID_W-1:0] sid, logic rs, logic aa, logic lst);
      planned_send_t exp_rec;
      if (planned_sends.size() == 0) begin
        report($sformatf("result with nothing pending, send_id %0d", sid));
      end else begin
        exp_rec = planned_sends.pop_front();
        if (sid !== exp_rec.send_id)
          report($sformatf("send_id %0d, want %0d", sid, exp_rec.send_id));
        if (rs !== exp_rec.is_resend)
          report($sformatf("is_resend %b, want %b (id %0d)", rs, exp_rec.is_resend, sid));
        if (aa !== exp_rec.all_acked)
          report($sformatf("all_acked %b, want %b (id %0d)", aa, exp_rec.all_acked, sid));
        if (lst !== exp_rec.last)
          report($sformatf("last %b, want %b (id %0d)", lst, exp_rec.last, sid));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [FUNC_W-1:0]      func_i = FN_START;
  logic [ID_W-1:0]        ack_id_i = '0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_WINDOW;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   result_valid_o;
  logic [ID_W-1:0]        send_id_o;
  logic                   is_resend_o;
  logic                   all_acked_o;
  logic                   last_o;

  sender_window_tracker tracker;
  int unsigned cycle_cnt;
  int unsigned rand_items = 0;
  bit quiet = 1'b0;

  selective_repeat_sender_window_unit i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .func_i,
    .ack_id_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .result_valid_o,
    .send_id_o,
    .is_resend_o,
    .all_acked_o,
    .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) tracker.match_send(send_id_o, is_resend_o, all_acked_o, last_o);
  end

  initial begin
    for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clk_i);
    $display("selective_repeat_sender_window_unit_tb: done, errors");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Holds the event until the block takes it; start stays high when no gap follows.
  task automatic send_event(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id);
    int unsigned gap;
    start_i <= 1'b1;
    func_i <= fn;
    ack_id_i <= id;
    do @(posedge clk_i); while (busy_o);
    tracker.take_event(fn, id);
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every result has arrived and the block reports idle.
  task automatic settle();
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (CFG_PAUSE) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit do_win, logic [CFG_DATA_W-1:0] win_data,
                           bit do_tot, logic [CFG_DATA_W-1:0] tot_data);
    if (do_win) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_WINDOW;
      cfg_data_i <= win_data;
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_reg(CFG_WINDOW, win_data);
    end
    if (do_tot) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_TOTAL;
      cfg_data_i <= tot_data;
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_reg(CFG_TOTAL, tot_data);
    end
    if (do_win || do_tot) cfg_valid_i <= 1'b0;
  endtask

  // Mostly acknowledgements of ids in flight, with timeouts, early and repeated
  // acknowledgements, stray ids, restarts and the undefined code mixed in.
  task automatic random_event();
    int unsigned r;
    int unsigned id;
    int unsigned t;
    int unsigned hi;
    r = $urandom_range(0, 99);
    t = tracker.eff_total();
    if (r < 4 || (tracker.unacked == 0 && r < 40)) begin
      send_event(FN_START, ID_W'($urandom));
    end else if (r < 62) begin
      id = tracker.pick_outstanding();
      if (id != 0) send_event(FN_ACK, ID_W'(id));
      else send_event(FN_TOUT, ID_W'($urandom));
    end else if (r < 74) begin
      send_event(FN_TOUT, ID_W'($urandom));
    end else if (r < 80) begin
      if (tracker.next_id <= t) begin
        hi = tracker.next_id + 64;
        if (hi > t) hi = t;
        send_event(FN_ACK, ID_W'($urandom_range(tracker.next_id, hi)));
      end else begin
        send_event(FN_ACK, ID_W'($urandom_range(0, 2047)));
      end
    end else if (r < 86) begin
      if (tracker.base > 0) send_event(FN_ACK, ID_W'($urandom_range(1, tracker.base)));
      else send_event(FN_ACK, '0);
    end else if (r < 96) begin
      send_event(FN_ACK, ID_W'($urandom_range(0, 2047)));
    end else begin
      send_event(FN_UNDEF, ID_W'($urandom));
    end
    rand_items++;
  endtask

  initial begin
    int unsigned r;
    int unsigned win_v;
    int unsigned tot_v;
    int unsigned n;
    logic [CFG_DATA_W-1:0] win_data;
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Before any start, only empty results; then a start with no packets.
    send_event(FN_ACK, 11'd5);
    send_event(FN_TOUT, '0);
    send_event(FN_UNDEF, '1);
    send_event(FN_START, '0);
    send_event(FN_ACK, 11'd1);

    // Window register zero acts as one; early, repeated and stray acknowledgements.
    settle();
    write_cfg(1'b1, '0, 1'b1, 11'd3);
    send_event(FN_START, '0);
    send_event(FN_ACK, 11'd3);
    send_event(FN_TOUT, '0);
    send_event(FN_TOUT, '0);
    send_event(FN_ACK, 11'd1);
    send_event(FN_ACK, 11'd2);
    send_event(FN_ACK, 11'd2);
    send_event(FN_ACK, 11'd0);
    send_event(FN_ACK, 11'd2047);

    // Both registers above their limits: full window sends and resends.
    settle();
    write_cfg(1'b1, 11'd63, 1'b1, 11'd2047);
    send_event(FN_START, '0);
    send_event(FN_TOUT, '0);
    send_event(FN_ACK, 11'd1024);
    send_event(FN_ACK, 11'd2047);
    send_event(FN_UNDEF, '0);
    send_event(FN_ACK, 11'd1);

    // The packet count moves under a running transfer.
    settle();
    write_cfg(1'b1, 11'd32, 1'b1, 11'd40);
    send_event(FN_ACK, 11'd2);
    send_event(FN_TOUT, '0);

    while (rand_items < RAND_ITEMS) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 10) win_v = 0;
      else if (r < 20) win_v = $urandom_range(33, 63);
      else if (r < 30) win_v = MAX_WIN;
      else win_v = $urandom_range(1, 16);
      win_data = CFG_DATA_W'(win_v) | (CFG_DATA_W'($urandom_range(0, 31)) << WIN_CFG_W);
      r = $urandom_range(0, 99);
      if (r < 8) tot_v = 0;
      else if (r < 16) tot_v = MAX_PKT;
      else if (r < 22) tot_v = $urandom_range(MAX_PKT + 1, 2047);
      else if (r < 30) tot_v = $urandom_range(100, MAX_PKT - 1);
      else tot_v = $urandom_range(1, 48);
      write_cfg($urandom_range(0, 9) < 7, win_data,
                $urandom_range(0, 9) < 7, CFG_DATA_W'(tot_v));
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        send_event(FN_START, ID_W'($urandom));
        rand_items++;
      end
      n = $urandom_range(4, 30);
      repeat (n) random_event();
    end

    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (END_PAUSE) @(posedge clk_i);
    if (tracker.mismatch_cnt == 0) begin
      $display("selective_repeat_sender_window_unit_tb: done, clean");
    end else begin
      $display("selective_repeat_sender_window_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
